FILE: rtl/core/ecp_pkg.sv
// Shared types and constants for the eviction candidate pool.
// Holds field widths, policy and register codes, and the structs passed
// between the score unit, the pool cells and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ecp_pkg;

    // Field widths
    localparam int KEY_W      = 32;
    localparam int DB_W       = 4;
    localparam int FIELD_W    = 24;
    localparam int EXPIRE_W   = 63;
    localparam int CLOCK_W    = 24;
    localparam int MIN_W      = 16;
    localparam int CNT_W      = 8;
    localparam int SCORE_W    = 64;
    localparam int SLOT_W     = 4;
    localparam int RES_W      = 16;
    localparam int POLICY_W   = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY  = 1'd1;

    // Policy codes; the unused code scores as soonest expiry
    localparam logic [POLICY_W-1:0] POLICY_LRU = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_LFU = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_TTL = 2'd2;

    // Register reset values
    localparam logic [POLICY_W-1:0] POLICY_RESET = POLICY_LRU;
    localparam logic [MIN_W-1:0]    DECAY_RESET  = 16'd1;

    // Parameter defaults
    localparam int POOL_ENTRIES_DEF     = 16;
    localparam int CLOCK_RESOLUTION_DEF = 1000;
    localparam int COUNTER_INIT_DEF     = 5;

    // Stream widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 232;

    typedef struct packed {
        logic [KEY_W-1:0]    key_handle;
        logic [DB_W-1:0]     db_index;
        logic [FIELD_W-1:0]  object_field;
        logic [EXPIRE_W-1:0] expire_time;
        logic [CLOCK_W-1:0]  now_clock;
        logic [MIN_W-1:0]    now_minutes;
    } in_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
        logic [DB_W-1:0]    db;
        logic [FIELD_W-1:0] new_field;
        logic               changed;
    } sample_t;

    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
        logic [DB_W-1:0]    db;
    } entry_t;

    typedef struct packed {
        logic load;
        logic full;
    } cell_ctrl_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [FIELD_W-1:0] new_object_field;
        logic               field_changed;
        logic               inserted;
        logic [SLOT_W-1:0]  slot;
        logic               dropped;
        logic [KEY_W-1:0]   dropped_key;
        logic               best_valid;
        logic [KEY_W-1:0]   best_key;
        logic [DB_W-1:0]    best_db;
        logic [SCORE_W-1:0] best_score;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/ecp_score.sv
// Two-stage score unit: age, frequency decay and expiry in the first stage,
// resolution multiply and score select in the second. Depends on ecp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecp_score #(
    parameter int CLOCK_RESOLUTION = ecp_pkg::CLOCK_RESOLUTION_DEF,
    parameter int COUNTER_INIT     = ecp_pkg::COUNTER_INIT_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [ecp_pkg::POLICY_W-1:0]     policy,
    input  wire  [ecp_pkg::MIN_W-1:0]        decay_minutes,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  ecp_pkg::in_item_t          in_item,
    output logic                             out_valid,
    input  wire                              out_ready,
    output ecp_pkg::sample_t                 out_sample
);
    import ecp_pkg::*;

    localparam logic [RES_W-1:0] RES       = RES_W'(CLOCK_RESOLUTION);
    localparam logic [CNT_W-1:0] CNT_FLOOR = CNT_W'(2 * COUNTER_INIT);
    localparam int               PROD_W    = CLOCK_W + RES_W;

    // Stage one registers
    logic                  v1_reg;
    logic [POLICY_W-1:0]   policy1_reg;
    logic [CLOCK_W-1:0]    age1_reg;
    logic [CNT_W-1:0]      cnt1_reg;
    logic [EXPIRE_W-1:0]   exp1_reg;
    logic [FIELD_W-1:0]    field1_reg;
    logic                  changed1_reg;
    logic [KEY_W-1:0]      key1_reg;
    logic [DB_W-1:0]       db1_reg;

    // Stage two registers
    logic                  v2_reg;
    sample_t               sample2_reg;

    logic                  adv1;
    logic                  adv2;
    logic [CLOCK_W-1:0]    age_next;
    logic [MIN_W-1:0]      ldt;
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      cnt_half;
    logic [CNT_W-1:0]      cnt_dec;
    logic [MIN_W-1:0]      elapsed;
    logic                  decay;
    logic [CNT_W-1:0]      cnt_next;
    logic [FIELD_W-1:0]    field_next;
    logic [PROD_W-1:0]     product;
    logic [SCORE_W-1:0]    score_next;

    // Stall a stage only when the one after it is full and stalled
    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Wrapped clock age and frequency decay
    always_comb
    begin
        if (in_item.now_clock >= in_item.object_field)
        begin
            age_next = in_item.now_clock - in_item.object_field;
        end
        else
        begin
            age_next = in_item.now_clock - in_item.object_field - CLOCK_W'(1);
        end

        ldt = in_item.object_field[FIELD_W-1:CNT_W];
        cnt = in_item.object_field[CNT_W-1:0];
        if (in_item.now_minutes >= ldt)
        begin
            elapsed = in_item.now_minutes - ldt;
        end
        else
        begin
            elapsed = in_item.now_minutes - ldt - MIN_W'(1);
        end

        cnt_half = cnt >> 1;
        if (cnt > CNT_FLOOR)
        begin
            cnt_dec = (cnt_half < CNT_FLOOR) ? CNT_FLOOR : cnt_half;
        end
        else
        begin
            cnt_dec = cnt - CNT_W'(1);
        end

        decay      = (policy == POLICY_LFU) && (elapsed >= decay_minutes) && (cnt != '0);
        cnt_next   = decay ? cnt_dec : cnt;
        field_next = decay ? {in_item.now_minutes, cnt_dec} : in_item.object_field;
    end

    // Stage one: capture partial scores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            policy1_reg  <= policy;
            age1_reg     <= age_next;
            cnt1_reg     <= 8'hFF - cnt_next;
            exp1_reg     <= in_item.expire_time;
            field1_reg   <= field_next;
            changed1_reg <= decay;
            key1_reg     <= in_item.key_handle;
            db1_reg      <= in_item.db_index;
        end
    end

    // Scale the age and pick the score of the policy
    always_comb
    begin
        product = PROD_W'(age1_reg) * PROD_W'(RES);
        unique case (policy1_reg)
            POLICY_LRU: score_next = SCORE_W'(product);
            POLICY_LFU: score_next = SCORE_W'(cnt1_reg);
            default:    score_next = ~{1'b0, exp1_reg};
        endcase
    end

    // Stage two: hold the finished sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            sample2_reg.score     <= score_next;
            sample2_reg.key       <= key1_reg;
            sample2_reg.db        <= db1_reg;
            sample2_reg.new_field <= field1_reg;
            sample2_reg.changed   <= changed1_reg;
        end
    end

    assign out_valid  = v2_reg;
    assign out_sample = sample2_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ecp_cell.sv
// One pool position: holds an entry, compares it with the incoming score
// and takes its own, its neighbor's or the new entry. Depends on ecp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecp_cell (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire  ecp_pkg::cell_ctrl_t ctrl,
    input  wire  ecp_pkg::entry_t   new_entry,
    input  wire  ecp_pkg::entry_t   left_entry,
    input  wire                     left_lt,
    input  wire  ecp_pkg::entry_t   right_entry,
    input  wire                     right_lt,
    output logic                    lt,
    output logic                    take_new,
    output ecp_pkg::entry_t         entry
);
    import ecp_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [DB_W-1:0]    db_reg;
    entry_t             cur;
    entry_t             entry_next;

    assign cur = '{valid: valid_reg, score: score_reg, key: key_reg, db: db_reg};
    assign lt  = valid_reg && (score_reg < new_entry.score);

    // Open a slot by shifting right into free space, or left when full
    always_comb
    begin
        if (ctrl.full)
        begin
            take_new = lt && !right_lt;
            if (right_lt)
            begin
                entry_next = right_entry;
            end
            else if (lt)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = cur;
            end
        end
        else
        begin
            take_new = !lt && left_lt;
            if (lt)
            begin
                entry_next = cur;
            end
            else if (left_lt)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        valid_next = entry_next.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            score_reg <= entry_next.score;
            key_reg   <= entry_next.key;
            db_reg    <= entry_next.db;
        end
    end

    assign entry = cur;

endmodule

`default_nettype wire

FILE: rtl/core/ecp_pool.sv
// Sorted candidate pool: a row of ecp_cell instances, the best-candidate
// register and the result register. Depends on ecp_pkg and ecp_cell.
`timescale 1ns / 1ps
`default_nettype none

module ecp_pool #(
    parameter int POOL_ENTRIES = ecp_pkg::POOL_ENTRIES_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  ecp_pkg::sample_t  sample,
    output logic                    out_valid,
    input  wire                     out_ready,
    output ecp_pkg::result_t        result
);
    import ecp_pkg::*;

    entry_t                  cells [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] lt;
    logic [POOL_ENTRIES-1:0] take_new;
    cell_ctrl_t              ctrl;
    entry_t                  new_entry;
    logic                    load;

    logic                    out_valid_reg;
    result_t                 result_reg;
    logic                    best_valid_reg;
    logic                    best_valid_next;
    entry_t                  best_reg;
    entry_t                  best_next;
    result_t                 result_next;
    logic [SLOT_W-1:0]       slot_v;

    assign in_ready  = !out_valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign ctrl.load = load;
    assign ctrl.full = cells[POOL_ENTRIES-1].valid;
    assign new_entry = '{valid: 1'b1, score: sample.score, key: sample.key, db: sample.db};

    // Row of cells, each wired to its two neighbors
    for (genvar i = 0; i < POOL_ENTRIES; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_l;
        logic   right_l;

        if (i == 0)
        begin : g_first
            assign left_e = '0;
            assign left_l = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_e = cells[i-1];
            assign left_l = lt[i-1];
        end

        if (i == POOL_ENTRIES - 1)
        begin : g_last
            assign right_e = '0;
            assign right_l = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_e = cells[i+1];
            assign right_l = lt[i+1];
        end

        ecp_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_lt     (left_l),
            .right_entry (right_e),
            .right_lt    (right_l),
            .lt          (lt[i]),
            .take_new    (take_new[i]),
            .entry       (cells[i])
        );
    end

    // Encode the slot that takes the sample
    always_comb
    begin
        slot_v = '0;
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            if (take_new[i])
            begin
                slot_v = slot_v | SLOT_W'(i);
            end
        end
    end

    // Track the top entry: a sample beating it lands on top
    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        if (!best_valid_reg || (sample.score > best_reg.score))
        begin
            best_valid_next = 1'b1;
            best_next       = new_entry;
        end

        result_next.score            = sample.score;
        result_next.new_object_field = sample.new_field;
        result_next.field_changed    = sample.changed;
        result_next.inserted         = |take_new;
        result_next.slot             = slot_v;
        result_next.dropped          = ctrl.full && lt[0];
        result_next.dropped_key      = (ctrl.full && lt[0]) ? cells[0].key : '0;
        result_next.best_valid       = 1'b1;
        result_next.best_key         = best_next.key;
        result_next.best_db          = best_next.db;
        result_next.best_score       = best_next.score;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            best_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (load)
            begin
                best_valid_reg <= best_valid_next;
                best_reg       <= best_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/eviction_candidate_pool.sv
// Eviction candidate pool: scores sampled keys and keeps the best victims.
// Top level; depends on ecp_pkg, ecp_score, ecp_cell and ecp_pool.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one sampled key per item. m_tvalid/
//   m_tready/m_tdata return one result item per sample, in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the policy (index 0) and
//   the decay time in minutes (index 1); cfg_ready is always high. The user
//   must make writes only while no item is in flight; the block does not enforce it.
//   A result passes the decay/age stage, the multiply stage, the pool row
//   and the result register before it is offered.
//   Throughput: one item per cycle while m_tready is high; the pool row
//   compares every entry with the new score and shifts in the same cycle,
//   so back-to-back samples see each other's inserts.
//   Reset empties the pool, clears the best candidate, and sets policy to
//   least recently used with a decay time of one minute.
//   When m_tready is low the result is held and the stages behind it fill;
//   s_tready falls once all three stages hold items, and nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module eviction_candidate_pool #(
    parameter int POOL_ENTRIES     = ecp_pkg::POOL_ENTRIES_DEF,
    parameter int CLOCK_RESOLUTION = ecp_pkg::CLOCK_RESOLUTION_DEF,
    parameter int COUNTER_INIT     = ecp_pkg::COUNTER_INIT_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // key_handle[31:0], db_index[35:32], object_field[59:36],
    // expire_time[122:60], now_clock[146:123], now_minutes[162:147], zero pad
    input  wire  [ecp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // score[63:0], new_object_field[87:64], field_changed[88], inserted[89],
    // slot[93:90], dropped[94], dropped_key[126:95], best_valid[127],
    // best_key[159:128], best_db[163:160], best_score[227:164], zero pad
    output logic [ecp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [ecp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [ecp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ecp_pkg::*;

    logic [POLICY_W-1:0] policy_reg;
    logic [MIN_W-1:0]    decay_reg;
    in_item_t            in_item;
    sample_t             sample;
    logic                sample_valid;
    logic                sample_ready;
    result_t             result;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RESET;
            decay_reg  <= DECAY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLICY: policy_reg <= cfg_data[POLICY_W-1:0];
                CFG_DECAY:  decay_reg  <= cfg_data[MIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Unpack the input item
    assign in_item.key_handle   = s_tdata[31:0];
    assign in_item.db_index     = s_tdata[35:32];
    assign in_item.object_field = s_tdata[59:36];
    assign in_item.expire_time  = s_tdata[122:60];
    assign in_item.now_clock    = s_tdata[146:123];
    assign in_item.now_minutes  = s_tdata[162:147];

    ecp_score #(
        .CLOCK_RESOLUTION (CLOCK_RESOLUTION),
        .COUNTER_INIT     (COUNTER_INIT)
    ) u_score (
        .clk           (clk),
        .rst_n         (rst_n),
        .policy        (policy_reg),
        .decay_minutes (decay_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (in_item),
        .out_valid     (sample_valid),
        .out_ready     (sample_ready),
        .out_sample    (sample)
    );

    ecp_pool #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .sample    (sample),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // Pack the result item
    assign m_tdata = {
        4'b0,
        result.best_score,
        result.best_db,
        result.best_key,
        result.best_valid,
        result.dropped_key,
        result.dropped,
        result.slot,
        result.inserted,
        result.field_changed,
        result.new_object_field,
        result.score
    };

endmodule

`default_nettype wire
